// ----- rtl/tpl_pkg.sv -----
// shared constants, types and tap table for the true-peak limiter
package tpl_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int TAP_COUNT   = 32;
  localparam int OVERSAMPLE  = 4;
  localparam int HIST_DEPTH  = TAP_COUNT / OVERSAMPLE;
  localparam int DELAY_DEPTH = 1024;
  localparam int DELAY_AW    = $clog2(DELAY_DEPTH);
  localparam int LEN_BITS    = 11;
  localparam int COEF_BITS   = 24;
  localparam int GAIN_BITS   = 25;
  localparam int GAIN_FRAC   = 24;
  localparam int TAP_BITS    = 17;
  localparam int MUL_BITS    = 26;
  localparam int PROD_BITS   = 2 * MUL_BITS;
  localparam int ACC_BITS    = 48;
  localparam int DIV_STEPS   = 24;
  localparam int CNT_BITS    = DELAY_AW;
  localparam int MAC_IW      = $clog2(TAP_COUNT);
  localparam int CFG_AW      = 3;

  localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << GAIN_FRAC;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_CEILING = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] REG_ATTACK  = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] REG_RELEASE = CFG_AW'(2);
  localparam logic [CFG_AW-1:0] REG_LOOKAHD = CFG_AW'(3);

  localparam logic signed [TAP_BITS-1:0] TAPS [TAP_COUNT] = '{
    17'sd0, -17'sd54, -17'sd231, -17'sd229, 17'sd431, 17'sd1727, 17'sd2644, 17'sd1592,
    -17'sd2233, -17'sd7406, -17'sd10080, -17'sd5712, 17'sd8012, 17'sd28858, 17'sd50144,
    17'sd63609, 17'sd63609, 17'sd50144, 17'sd28858, 17'sd8012, -17'sd5712, -17'sd10080,
    -17'sd7406, -17'sd2233, 17'sd1592, 17'sd2644, 17'sd1727, 17'sd431, -17'sd229,
    -17'sd231, -17'sd54, 17'sd0
  };

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MAC, ST_DRAIN, ST_CMP, ST_DIV,
    ST_GAIN_A, ST_GAIN_B, ST_GAIN_U, ST_OUT_MUL, ST_OUT_FIN
  } state_t;

  typedef struct packed {
    logic                load;
    logic                mac_en;
    logic                mac_first;
    logic                mac_last;
    logic [MAC_IW-1:0]   mac_idx;
    logic                div_init;
    logic                div_step;
    logic                gain_a;
    logic                gain_b;
    logic                gain_upd;
    logic                out_mul;
    logic                out_fin;
    logic                clr_wr;
    logic [DELAY_AW-1:0] clr_addr;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] ceiling;
    logic [COEF_BITS-1:0]   attack;
    logic [COEF_BITS-1:0]   release_c;
    logic [LEN_BITS-1:0]    lookahead;
  } cfg_t;

endpackage

// ----- rtl/tpl_ram.sv -----
// generic ram with separate write and read ports and registered read
module tpl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/tpl_ctrl.sv -----
// sequencer for ram clear, mac, division, gain smoothing and output steps
module tpl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tpl_pkg::status_t sts,
  output tpl_pkg::cmd_t    cmd
);

  tpl_pkg::state_t state_r, state_nxt;
  logic [tpl_pkg::CNT_BITS-1:0] cnt_r, cnt_nxt;

  // state and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpl_pkg::ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.mac_idx  = cnt_r[tpl_pkg::MAC_IW-1:0];
    cmd.clr_addr = cnt_r[tpl_pkg::DELAY_AW-1:0];
    case (state_r)
      tpl_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (&cnt_r) begin
          state_nxt = tpl_pkg::ST_IDLE;
        end
      end
      tpl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = tpl_pkg::ST_MAC;
        end
      end
      tpl_pkg::ST_MAC: begin
        cmd.mac_en    = 1'b1;
        cmd.mac_first = (cnt_r[2:0] == 3'd0);
        cmd.mac_last  = (&cnt_r[2:0]);
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r[tpl_pkg::MAC_IW-1:0] == tpl_pkg::MAC_IW'(tpl_pkg::TAP_COUNT - 1)) begin
          cnt_nxt   = '0;
          state_nxt = tpl_pkg::ST_DRAIN;
        end
      end
      tpl_pkg::ST_DRAIN: begin
        state_nxt = tpl_pkg::ST_CMP;
      end
      tpl_pkg::ST_CMP: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = sts.need_div ? tpl_pkg::ST_DIV : tpl_pkg::ST_GAIN_A;
      end
      tpl_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == tpl_pkg::CNT_BITS'(tpl_pkg::DIV_STEPS - 1)) begin
          state_nxt = tpl_pkg::ST_GAIN_A;
        end
      end
      tpl_pkg::ST_GAIN_A: begin
        cmd.gain_a = 1'b1;
        state_nxt  = tpl_pkg::ST_GAIN_B;
      end
      tpl_pkg::ST_GAIN_B: begin
        cmd.gain_b = 1'b1;
        state_nxt  = tpl_pkg::ST_GAIN_U;
      end
      tpl_pkg::ST_GAIN_U: begin
        cmd.gain_upd = 1'b1;
        state_nxt    = tpl_pkg::ST_OUT_MUL;
      end
      tpl_pkg::ST_OUT_MUL: begin
        cmd.out_mul = 1'b1;
        state_nxt   = tpl_pkg::ST_OUT_FIN;
      end
      tpl_pkg::ST_OUT_FIN: begin
        // hold the product until the output register is free
        if (sts.out_free) begin
          cmd.out_fin = 1'b1;
          state_nxt   = tpl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tpl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/tpl_dpath.sv -----
// history, shared multiplier, peak search, divider, gain, delay line and output rounding
module tpl_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tpl_pkg::cfg_t                        cfg,
  input  tpl_pkg::cmd_t                        cmd,
  output tpl_pkg::status_t                     sts,
  input  logic signed [tpl_pkg::SAMPLE_BITS-1:0] x_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tpl_pkg::SAMPLE_BITS-1:0]      out_data
);

  localparam int SB = tpl_pkg::SAMPLE_BITS;
  localparam int MB = tpl_pkg::MUL_BITS;
  localparam int PB = tpl_pkg::PROD_BITS;
  localparam int AB = tpl_pkg::ACC_BITS;
  localparam int GB = tpl_pkg::GAIN_BITS;
  localparam int RB = AB + 2;
  localparam int YB = PB - tpl_pkg::GAIN_FRAC;

  logic signed [SB-1:0] hist_r [tpl_pkg::HIST_DEPTH];
  logic signed [SB-1:0] x_r;
  logic signed [PB-1:0] prod_r, part_r;
  logic signed [MB-1:0] mul_a, mul_b;
  logic                 acc_en_r, acc_first_r, acc_last_r;
  logic signed [AB-1:0] acc_r, acc_sum;
  logic [AB-1:0]        peak_r, mag;
  logic [RB-1:0]        rem_r, rem2;
  logic [GB-1:0]        target_r, g_r;
  logic [tpl_pkg::COEF_BITS-1:0] coef;
  logic [tpl_pkg::DELAY_AW-1:0]  ptr_r;
  logic [tpl_pkg::LEN_BITS-1:0]  len_eff, ptr_inc;
  logic [SB-1:0]        rdata;
  logic                 ram_we;
  logic [tpl_pkg::DELAY_AW-1:0] ram_waddr;
  logic [SB-1:0]        ram_wdata;
  logic signed [PB-1:0] rnd;
  logic signed [YB-1:0] y0, y1, y2, ceil_s;
  logic [PB-1:0]        gsum;
  logic                 out_valid_r;
  logic [SB-1:0]        out_data_r;
  logic [tpl_pkg::MAC_IW-1:0] tap_sel;
  logic                 need_div;
  logic                 out_free;

  // sample history, newest at index zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tpl_pkg::HIST_DEPTH; i++) hist_r[i] <= '0;
    end else if (cmd.load) begin
      hist_r[0] <= x_in;
      for (int i = 1; i < tpl_pkg::HIST_DEPTH; i++) hist_r[i] <= hist_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= x_in;
    end
  end

  // operand selection for the shared multiplier
  assign tap_sel = {cmd.mac_idx[2:0], cmd.mac_idx[tpl_pkg::MAC_IW-1:3]};
  assign coef    = (target_r < g_r) ? cfg.attack : cfg.release_c;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.mac_en) begin
      mul_a = MB'(tpl_pkg::TAPS[tap_sel]);
      mul_b = MB'(hist_r[cmd.mac_idx[2:0]]);
    end else if (cmd.gain_a) begin
      mul_a = {{(MB - tpl_pkg::COEF_BITS){1'b0}}, coef};
      mul_b = {{(MB - GB){1'b0}}, g_r};
    end else if (cmd.gain_b) begin
      mul_a = {{(MB - GB){1'b0}}, tpl_pkg::GAIN_ONE - {1'b0, coef}};
      mul_b = {{(MB - GB){1'b0}}, target_r};
    end else if (cmd.out_mul) begin
      mul_a = MB'($signed(rdata));
      mul_b = {{(MB - GB){1'b0}}, g_r};
    end
  end

  // product held while no multiply step runs
  always_ff @(posedge clk) begin
    if (cmd.mac_en || cmd.gain_a || cmd.gain_b || cmd.out_mul) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.gain_b) begin
      part_r <= prod_r;
    end
  end

  // accumulate stage follows the multiply in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r    <= 1'b0;
      acc_first_r <= 1'b0;
      acc_last_r  <= 1'b0;
    end else begin
      acc_en_r    <= cmd.mac_en;
      acc_first_r <= cmd.mac_first;
      acc_last_r  <= cmd.mac_last;
    end
  end

  assign acc_sum = (acc_first_r ? AB'(0) : acc_r) + prod_r[AB-1:0];
  assign mag     = acc_sum[AB-1] ? AB'(-acc_sum) : AB'(acc_sum);

  // phase sums and running peak
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      peak_r <= '0;
    end else if (acc_en_r) begin
      acc_r <= acc_sum;
      if (acc_last_r && (mag > peak_r)) begin
        peak_r <= mag;
      end
    end
  end

  assign need_div = peak_r > {{(AB - SB - 16){1'b0}}, cfg.ceiling, 16'd0};

  // restoring divider, one quotient bit per cycle
  assign rem2 = {rem_r[RB-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r    <= {{(RB - SB - 16){1'b0}}, cfg.ceiling, 16'd0};
      target_r <= need_div ? GB'(0) : tpl_pkg::GAIN_ONE;
    end else if (cmd.div_step) begin
      if (rem2 >= {2'b00, peak_r}) begin
        rem_r    <= rem2 - {2'b00, peak_r};
        target_r <= {target_r[GB-2:0], 1'b1};
      end else begin
        rem_r    <= rem2;
        target_r <= {target_r[GB-2:0], 1'b0};
      end
    end
  end

  // smoothed gain
  assign gsum = part_r + prod_r + (PB'(1) << (tpl_pkg::GAIN_FRAC - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_r <= tpl_pkg::GAIN_ONE;
    end else if (cmd.gain_upd) begin
      g_r <= gsum[tpl_pkg::GAIN_FRAC +: GB];
    end
  end

  // lookahead delay line
  always_comb begin
    if (cfg.lookahead == '0) begin
      len_eff = tpl_pkg::LEN_BITS'(1);
    end else if (cfg.lookahead > tpl_pkg::LEN_BITS'(tpl_pkg::DELAY_DEPTH)) begin
      len_eff = tpl_pkg::LEN_BITS'(tpl_pkg::DELAY_DEPTH);
    end else begin
      len_eff = cfg.lookahead;
    end
  end

  assign ptr_inc   = {1'b0, ptr_r} + 1'b1;
  assign ram_we    = cmd.out_fin | cmd.clr_wr;
  assign ram_waddr = cmd.clr_wr ? cmd.clr_addr : ptr_r;
  assign ram_wdata = cmd.clr_wr ? SB'(0) : x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (cmd.out_fin) begin
      ptr_r <= (ptr_inc >= len_eff) ? '0 : ptr_inc[tpl_pkg::DELAY_AW-1:0];
    end
  end

  tpl_ram #(
    .WIDTH(SB),
    .DEPTH(tpl_pkg::DELAY_DEPTH)
  ) u_delay (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ptr_r),
    .rdata(rdata)
  );

  // rounding and clipping of the output sample
  assign rnd    = prod_r + (PB'(1) << (tpl_pkg::GAIN_FRAC - 1));
  assign y0     = rnd[PB-1:tpl_pkg::GAIN_FRAC];
  assign ceil_s = {{(YB - SB){1'b0}}, cfg.ceiling};

  always_comb begin
    y1 = y0;
    if (y0 > ceil_s) y1 = ceil_s;
    if (y0 < -ceil_s) y1 = -ceil_s;
    y2 = y1;
    if (y1 > YB'(2 ** (SB - 1) - 1)) y2 = YB'(2 ** (SB - 1) - 1);
    if (y1 < -YB'(2 ** (SB - 1))) y2 = -YB'(2 ** (SB - 1));
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_fin) begin
      out_data_r <= y2[SB-1:0];
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign sts       = {need_div, out_free};
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/true_peak_lookahead_limiter_top.sv -----
// top level of the true-peak lookahead limiter
// sequence: an accepted input beat runs the mac, drain, compare, divide, gain and output
//   steps; the divide is skipped when the peak is not above the ceiling, and out_tvalid
//   rises after the output step, later if the previous output beat is still waiting; one
//   beat is taken at a time: 32 serial taps on one multiplier and a bit-serial divider
// reset: synchronous active-low; the sequencer, config, history, gain, pointer and out_tvalid
//   registers return to defaults, then a pass zeroes the delay ram while in_tready stays low
module true_peak_lookahead_limiter_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [tpl_pkg::SAMPLE_BITS-1:0]      in_tdata,   // [23:0] sample_in
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [tpl_pkg::SAMPLE_BITS-1:0]      out_tdata,  // [23:0] sample_out
  input  logic                                 cfg_we,
  input  logic [tpl_pkg::CFG_AW-1:0]           cfg_addr,
  input  logic [tpl_pkg::COEF_BITS-1:0]        cfg_wdata
);

  tpl_pkg::cfg_t    cfg_r;
  tpl_pkg::cmd_t    cmd;
  tpl_pkg::status_t sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ceiling   <= 24'd7476347;
      cfg_r.attack    <= 24'd16427000;
      cfg_r.release_c <= 24'd16773000;
      cfg_r.lookahead <= 11'd240;
    end else if (cfg_we) begin
      case (cfg_addr)
        tpl_pkg::REG_CEILING: cfg_r.ceiling   <= cfg_wdata;
        tpl_pkg::REG_ATTACK:  cfg_r.attack    <= cfg_wdata;
        tpl_pkg::REG_RELEASE: cfg_r.release_c <= cfg_wdata;
        tpl_pkg::REG_LOOKAHD: cfg_r.lookahead <= cfg_wdata[tpl_pkg::LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  tpl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  tpl_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd      (cmd),
    .sts      (sts),
    .x_in     ($signed(in_tdata)),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_tdata)
  );

endmodule

// ----- rtl/tpl_checker.sv -----
// port-level checks for the limiter, bound to the top level
module tpl_props (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready
);

  // a waiting output beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat withdrawn");

  // one beat in flight: no second accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // a result cannot appear in the cycle after an accept
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("output beat too early");

  // clearing pass holds off input after reset
  a_clear: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready during ram clear");

endmodule

bind true_peak_lookahead_limiter_top tpl_props u_tpl_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready)
);
